[src/kpt_pkg.sv]
// Shared constants and types of the keypad press tracker.
// No dependencies; the lanes, the merge stage and the top level import it.
`timescale 1ns / 1ps

package kpt_pkg;

    localparam int NUM_KEYS    = 10;
    localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
    localparam int QUERY_BITS  = 4;
    localparam int TIME_BITS   = 32;
    localparam int TAP_BITS    = 8;
    localparam int WIN_BITS    = 16;

    typedef logic [TIME_BITS-1:0]  stamp_t;
    typedef logic [NUM_KEYS-1:0]   keys_t;
    typedef logic [TAP_BITS-1:0]   tap_t;
    typedef logic [WIN_BITS-1:0]   window_t;
    typedef logic [QUERY_BITS-1:0] query_t;

    localparam window_t WINDOW_RESET = window_t'(100);
    localparam tap_t    TAP_MAX      = {TAP_BITS{1'b1}};
    localparam tap_t    TAP_ONE      = tap_t'(1);
    localparam keys_t   ACTIVE_KEYS  = {NUM_KEYS{1'b1}};

    // Everything one key remembers.
    typedef struct packed {
        stamp_t press_time;
        stamp_t prev_press_time;
        stamp_t release_time;
        stamp_t hold_time;
        tap_t   tap_count;
    } key_rec_t;

    // What the first stage hands to the merge stage for one item.
    typedef struct packed {
        keys_t  pressed;
        keys_t  released;
        keys_t  held;
        stamp_t idle;
        query_t query;
    } tick_t;

endpackage

[src/kpt_lane.sv]
// One key's record and its update logic; one copy runs per key.
// Depends on kpt_pkg.
`timescale 1ns / 1ps

module kpt_lane import kpt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     upd,
    input  logic     key_down,
    input  logic     key_last,
    input  stamp_t   now,
    input  window_t  tap_window,
    output key_rec_t rec
);

    key_rec_t rec_reg;
    key_rec_t rec_next;
    logic     went_down;
    logic     went_up;
    logic     late;

    assign went_down = key_down & ~key_last;
    assign went_up   = ~key_down & key_last;

    // The release time plus the window is formed one bit wider so it cannot wrap.
    assign late = {1'b0, now} >
                  ({1'b0, rec_reg.release_time} + (TIME_BITS+1)'(tap_window));

    always_comb begin
        rec_next = rec_reg;
        if (upd) begin
            if (went_down) begin
                if (late) begin
                    rec_next.tap_count = TAP_ONE;
                end else if (rec_reg.tap_count != TAP_MAX) begin
                    rec_next.tap_count = rec_reg.tap_count + TAP_ONE;
                end
                rec_next.prev_press_time = rec_reg.press_time;
                rec_next.press_time      = now;
            end
            if (key_down) begin
                rec_next.hold_time = now - rec_next.press_time;
            end
            if (went_up) begin
                rec_next.release_time = now;
                rec_next.hold_time    = now - rec_reg.press_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

[src/kpt_merge.sv]
// Merge stage: picks the queried key's record from the lanes and holds the result item.
// Depends on kpt_pkg.
`timescale 1ns / 1ps

module kpt_merge import kpt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     tick_valid,
    output logic     tick_ready,
    input  tick_t    tick,
    input  key_rec_t recs [NUM_KEYS],
    output logic     m_valid,
    input  logic     m_ready,
    output keys_t    m_pressed_mask,
    output keys_t    m_released_mask,
    output keys_t    m_held_mask,
    output stamp_t   m_idle_ticks,
    output logic     m_key_valid,
    output stamp_t   m_key_press_time,
    output stamp_t   m_key_prev_press_time,
    output stamp_t   m_key_release_time,
    output stamp_t   m_key_hold_time,
    output tap_t     m_key_tap_count
);

    logic     m_valid_reg;
    logic     m_valid_next;
    logic     load;
    logic     sel_valid;
    key_rec_t sel_rec;
    tick_t    tick_reg;
    logic     key_valid_reg;
    key_rec_t rec_reg;

    assign tick_ready = !m_valid_reg || m_ready;
    assign load       = tick_valid && tick_ready;

    // A query beyond the last key reports an all-zero record.
    always_comb begin
        sel_valid = (tick.query < QUERY_BITS'(NUM_KEYS));
        sel_rec   = '0;
        if (sel_valid) begin
            sel_rec = recs[tick.query[KEY_IDX_W-1:0]];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tick_reg      <= tick;
            key_valid_reg <= sel_valid;
            rec_reg       <= sel_rec;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_pressed_mask        = tick_reg.pressed;
    assign m_released_mask       = tick_reg.released;
    assign m_held_mask           = tick_reg.held;
    assign m_idle_ticks          = tick_reg.idle;
    assign m_key_valid           = key_valid_reg;
    assign m_key_press_time      = rec_reg.press_time;
    assign m_key_prev_press_time = rec_reg.prev_press_time;
    assign m_key_release_time    = rec_reg.release_time;
    assign m_key_hold_time       = rec_reg.hold_time;
    assign m_key_tap_count       = rec_reg.tap_count;

endmodule

[src/keypad_press_tracker_top.sv]
// Keypad press tracker: edge masks, per-key press records, tap counts and idle time.
// Depends on kpt_pkg, kpt_lane and kpt_merge.
//
// Usage:
// The input channel (s_valid/s_ready) takes one item per keypad tick: the key
// levels, the time stamp and the index of the key whose record is wanted.
// The result channel (m_valid/m_ready) gives one item per input item: the
// pressed, released and held masks, the idle time and the queried record.
// The tap window is written through cfg_we/cfg_wdata while the block is idle.
// One item per cycle is sustained while m_ready stays high. An accepted item
// updates all key records at once, one lane per key, and its result passes
// through the lane update stage and then the merge register that selects the
// queried record.
// When the receiver stalls, the result is held and one further item waits in
// the first stage; s_ready then drops until m_ready returns.
// Reset (aresetn low, synchronous) clears all key records, the last key
// levels and the activity time, sets the tap window to 100 and empties both
// stages.
`timescale 1ns / 1ps

module keypad_press_tracker_top import kpt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [9:0]   s_keys_down,
    input  logic [31:0]  s_now,
    input  logic [3:0]   s_query_key,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [9:0]   m_pressed_mask,
    output logic [9:0]   m_released_mask,
    output logic [9:0]   m_held_mask,
    output logic [31:0]  m_idle_ticks,
    output logic         m_key_valid,
    output logic [31:0]  m_key_press_time,
    output logic [31:0]  m_key_prev_press_time,
    output logic [31:0]  m_key_release_time,
    output logic [31:0]  m_key_hold_time,
    output logic [7:0]   m_key_tap_count
);

    window_t  tap_window_reg;
    keys_t    last_keys_reg;
    keys_t    last_keys_next;
    stamp_t   last_activity_reg;
    stamp_t   last_activity_next;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    tick_t    tick_reg;
    tick_t    tick_next;
    logic     accept;
    logic     merge_ready;
    keys_t    keys;
    stamp_t   now;
    key_rec_t recs [NUM_KEYS];

    assign keys   = keys_t'(s_keys_down);
    assign now    = stamp_t'(s_now);
    assign s_ready = !s1_valid_reg || merge_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_window_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            tap_window_reg <= window_t'(cfg_wdata);
        end
    end

    always_comb begin
        last_keys_next     = last_keys_reg;
        last_activity_next = last_activity_reg;
        tick_next          = tick_reg;
        if (accept) begin
            last_keys_next = keys;
            if ((keys & ACTIVE_KEYS) != '0) begin
                last_activity_next = now;
            end
            tick_next.pressed  = keys & ~last_keys_reg;
            tick_next.released = last_keys_reg & ~keys;
            tick_next.held     = keys;
            tick_next.idle     = now - last_activity_next;
            tick_next.query    = query_t'(s_query_key);
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (merge_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_keys_reg     <= '0;
            last_activity_reg <= '0;
            s1_valid_reg      <= 1'b0;
        end else begin
            last_keys_reg     <= last_keys_next;
            last_activity_reg <= last_activity_next;
            s1_valid_reg      <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tick_reg <= tick_next;
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kpt_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .upd        (accept),
            .key_down   (keys[k]),
            .key_last   (last_keys_reg[k]),
            .now        (now),
            .tap_window (tap_window_reg),
            .rec        (recs[k])
        );
    end

    // The merge register loads in the same edge at which the next item may
    // update the lanes, so it always sees the records left by its own item.
    kpt_merge u_merge (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .tick_valid            (s1_valid_reg),
        .tick_ready            (merge_ready),
        .tick                  (tick_reg),
        .recs                  (recs),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_pressed_mask        (m_pressed_mask),
        .m_released_mask       (m_released_mask),
        .m_held_mask           (m_held_mask),
        .m_idle_ticks          (m_idle_ticks),
        .m_key_valid           (m_key_valid),
        .m_key_press_time      (m_key_press_time),
        .m_key_prev_press_time (m_key_prev_press_time),
        .m_key_release_time    (m_key_release_time),
        .m_key_hold_time       (m_key_hold_time),
        .m_key_tap_count       (m_key_tap_count)
    );

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item did not reach the first stage");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a held result");

    a_pressed_is_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pressed_mask & ~m_held_mask) == '0))
        else $error("pressed key not shown as held");

    a_released_not_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_released_mask & m_held_mask) == '0))
        else $error("released key shown as held");

    a_bad_query_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_key_valid) |-> (m_key_tap_count == '0 && m_key_press_time == '0))
        else $error("out-of-range query returned a record");

endmodule

[tb/keypad_press_tracker_checker.sv]
// Checker for the keypad press tracker: watches both channels and the tap window writes,
// predicts every result item and compares it field by field. Depends on kpt_pkg.
`timescale 1ns / 1ps

module keypad_press_tracker_checker import kpt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_valid,
    input  logic         s_ready,
    input  logic [9:0]   s_keys_down,
    input  logic [31:0]  s_now,
    input  logic [3:0]   s_query_key,
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic [9:0]   m_pressed_mask,
    input  logic [9:0]   m_released_mask,
    input  logic [9:0]   m_held_mask,
    input  logic [31:0]  m_idle_ticks,
    input  logic         m_key_valid,
    input  logic [31:0]  m_key_press_time,
    input  logic [31:0]  m_key_prev_press_time,
    input  logic [31:0]  m_key_release_time,
    input  logic [31:0]  m_key_hold_time,
    input  logic [7:0]   m_key_tap_count,
    output int           fail_count,
    output int           outstanding
);

    typedef struct {
        keys_t  pressed;
        keys_t  released;
        keys_t  held;
        stamp_t idle;
        logic   rec_valid;
        stamp_t press_at;
        stamp_t prev_press_at;
        stamp_t release_at;
        stamp_t hold_len;
        tap_t   taps;
    } tick_report_t;

    // Shadow copy of the tracker's state and its tap window.
    window_t window;
    keys_t   prev_keys;
    stamp_t  activity_at;
    stamp_t  key_press_at[NUM_KEYS];
    stamp_t  key_prev_press_at[NUM_KEYS];
    stamp_t  key_release_at[NUM_KEYS];
    stamp_t  key_hold_len[NUM_KEYS];
    tap_t    key_taps[NUM_KEYS];

    tick_report_t expected_reports[$];
    int errors = 0;
    int pending_reports = 0;

    assign fail_count  = errors;
    assign outstanding = pending_reports;

    function automatic tick_report_t track_tick(keys_t keys, stamp_t now, query_t q);
        tick_report_t rep;
        keys_t        went_down;
        keys_t        went_up;
        logic         late;
        if ((keys & ACTIVE_KEYS) != '0)
            activity_at = now;
        went_down = keys & ~prev_keys;
        went_up   = prev_keys & ~keys;
        prev_keys = keys;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (went_down[k]) begin
                // The window sum is taken one bit wider so that it cannot wrap.
                late = {1'b0, now} > ({1'b0, key_release_at[k]} + 33'(window));
                if (late)
                    key_taps[k] = TAP_ONE;
                else if (key_taps[k] != TAP_MAX)
                    key_taps[k] = key_taps[k] + 1'b1;
                key_prev_press_at[k] = key_press_at[k];
                key_press_at[k]      = now;
            end
            if (keys[k])
                key_hold_len[k] = now - key_press_at[k];
            if (went_up[k]) begin
                key_release_at[k] = now;
                key_hold_len[k]   = now - key_press_at[k];
            end
        end
        rep.pressed  = went_down;
        rep.released = went_up;
        rep.held     = keys;
        rep.idle     = now - activity_at;
        if (q < NUM_KEYS) begin
            rep.rec_valid     = 1'b1;
            rep.press_at      = key_press_at[q];
            rep.prev_press_at = key_prev_press_at[q];
            rep.release_at    = key_release_at[q];
            rep.hold_len      = key_hold_len[q];
            rep.taps          = key_taps[q];
        end else begin
            rep.rec_valid     = 1'b0;
            rep.press_at      = '0;
            rep.prev_press_at = '0;
            rep.release_at    = '0;
            rep.hold_len      = '0;
            rep.taps          = '0;
        end
        return rep;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : track
        tick_report_t want;
        if (!aresetn) begin
            window      = WINDOW_RESET;
            prev_keys   = '0;
            activity_at = '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                key_press_at[k]      = '0;
                key_prev_press_at[k] = '0;
                key_release_at[k]    = '0;
                key_hold_len[k]      = '0;
                key_taps[k]          = '0;
            end
            expected_reports.delete();
        end else begin
            // Results are matched before this edge's input item is added, as no
            // item can come out in the cycle that it goes in.
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result item arrived with no expectation waiting", $time);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("pressed_mask", want.pressed, m_pressed_mask);
                    compare_field("released_mask", want.released, m_released_mask);
                    compare_field("held_mask", want.held, m_held_mask);
                    compare_field("idle_ticks", want.idle, m_idle_ticks);
                    compare_field("key_valid", want.rec_valid, m_key_valid);
                    compare_field("key_press_time", want.press_at, m_key_press_time);
                    compare_field("key_prev_press_time", want.prev_press_at,
                                  m_key_prev_press_time);
                    compare_field("key_release_time", want.release_at, m_key_release_time);
                    compare_field("key_hold_time", want.hold_len, m_key_hold_time);
                    compare_field("key_tap_count", want.taps, m_key_tap_count);
                end
            end
            if (cfg_we)
                window = cfg_wdata;
            if (s_valid && s_ready)
                expected_reports.push_back(track_tick(s_keys_down, s_now, s_query_key));
        end
        pending_reports <= expected_reports.size();
    end

endmodule

[tb/tb_keypad_press_tracker_top.sv]
// Testbench top for the keypad press tracker: clock, reset, tap window writes and
// key stimulus with random idling. Depends on kpt_pkg, the block and the checker.
`timescale 1ns / 1ps

module tb_keypad_press_tracker_top;
    import kpt_pkg::*;

    typedef enum {TAP_FINE, TAP_WIDE, HOLD_STEADY, NOISE} stim_mode_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_wdata   = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [9:0]  s_keys_down = '0;
    logic [31:0] s_now       = '0;
    logic [3:0]  s_query_key = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [9:0]  m_pressed_mask;
    logic [9:0]  m_released_mask;
    logic [9:0]  m_held_mask;
    logic [31:0] m_idle_ticks;
    logic        m_key_valid;
    logic [31:0] m_key_press_time;
    logic [31:0] m_key_prev_press_time;
    logic [31:0] m_key_release_time;
    logic [31:0] m_key_hold_time;
    logic [7:0]  m_key_tap_count;

    int fail_count;
    int outstanding;

    int      send_idle_pct = 28;
    int      recv_idle_pct = 73;
    int      items_sent    = 0;
    window_t cur_window    = WINDOW_RESET;
    stamp_t  tick_now      = '0;
    keys_t   key_levels    = '0;

    keypad_press_tracker_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_keys_down(s_keys_down), .s_now(s_now), .s_query_key(s_query_key),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pressed_mask(m_pressed_mask), .m_released_mask(m_released_mask),
        .m_held_mask(m_held_mask), .m_idle_ticks(m_idle_ticks),
        .m_key_valid(m_key_valid), .m_key_press_time(m_key_press_time),
        .m_key_prev_press_time(m_key_prev_press_time),
        .m_key_release_time(m_key_release_time), .m_key_hold_time(m_key_hold_time),
        .m_key_tap_count(m_key_tap_count)
    );

    keypad_press_tracker_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_keys_down(s_keys_down), .s_now(s_now), .s_query_key(s_query_key),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pressed_mask(m_pressed_mask), .m_released_mask(m_released_mask),
        .m_held_mask(m_held_mask), .m_idle_ticks(m_idle_ticks),
        .m_key_valid(m_key_valid), .m_key_press_time(m_key_press_time),
        .m_key_prev_press_time(m_key_prev_press_time),
        .m_key_release_time(m_key_release_time), .m_key_hold_time(m_key_hold_time),
        .m_key_tap_count(m_key_tap_count),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        #10_000_000;
        $display("keypad_press_tracker_top verification failed");
        $finish;
    end

    // Offers one item and returns at the edge where it is taken.
    task automatic offer_tick(keys_t keys, stamp_t now, query_t q);
        if (items_sent < 420) begin
            send_idle_pct = 28;
            recv_idle_pct = 73;
        end else if (items_sent < 840) begin
            send_idle_pct = 73;
            recv_idle_pct = 28;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_keys_down <= keys;
        s_now       <= now;
        s_query_key <= q;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_window(window_t w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cur_window = w;
    endtask

    // Random key traffic in bursts; a saturating run keeps tapping with tiny
    // time steps so that the tap counts reach their ceiling.
    task automatic run_keys(int count, bit saturating);
        stim_mode_t mode;
        int         burst_left;
        int         pick;
        keys_t      flip;
        stamp_t     fine_span;
        stamp_t     wide_span;
        query_t     q;
        fine_span  = cur_window >> 6;
        wide_span  = stamp_t'(cur_window) + (cur_window >> 2) + 2;
        burst_left = 0;
        mode       = TAP_FINE;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(5, 40);
                pick = $urandom_range(0, 99);
                if (saturating)
                    mode = TAP_FINE;
                else if (pick < 40)
                    mode = TAP_WIDE;
                else if (pick < 60)
                    mode = TAP_FINE;
                else if (pick < 85)
                    mode = HOLD_STEADY;
                else
                    mode = NOISE;
            end
            burst_left--;
            if ($urandom_range(0, 4) == 0)
                q = query_t'($urandom_range(0, 15));
            else
                q = query_t'($urandom_range(0, NUM_KEYS - 1));
            case (mode)
                TAP_FINE: begin
                    flip = ~(keys_t'($urandom) & keys_t'($urandom) &
                             keys_t'($urandom) & keys_t'($urandom));
                    key_levels = key_levels ^ flip;
                    tick_now   = tick_now + $urandom_range(0, fine_span);
                end
                TAP_WIDE: begin
                    key_levels = key_levels ^ keys_t'($urandom);
                    tick_now   = tick_now + $urandom_range(0, wide_span);
                end
                HOLD_STEADY: begin
                    if ($urandom_range(0, 7) == 0)
                        key_levels[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
                    tick_now = tick_now + $urandom_range(0, 32'h00FF_FFFF);
                end
                default: begin
                    key_levels = keys_t'($urandom);
                    tick_now   = stamp_t'($urandom);
                    q          = query_t'($urandom_range(0, 15));
                end
            endcase
            offer_tick(key_levels, tick_now, q);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset window of 100.
        offer_tick(10'h000, 32'd0, 4'd0);
        offer_tick(10'h3FF, 32'd5, 4'd0);
        offer_tick(10'h3FF, 32'd50, 4'd9);
        offer_tick(10'h000, 32'd60, 4'd15);
        // A press exactly one window after the release still extends the count.
        offer_tick(10'h001, 32'd160, 4'd0);
        offer_tick(10'h000, 32'd170, 4'd0);
        // One tick past the window restarts it.
        offer_tick(10'h001, 32'd271, 4'd0);
        offer_tick(10'h200, 32'hFFFF_FFFF, 4'd9);
        // Time wraps: hold and idle differences wrap too.
        offer_tick(10'h000, 32'h0000_0010, 4'd9);
        // A press stamped earlier than the release counts as inside the window.
        offer_tick(10'h200, 32'h0000_0005, 4'd9);
        offer_tick(10'h155, 32'h8000_0000, 4'd10);
        offer_tick(10'h2AA, 32'h8000_0001, 4'd4);
        offer_tick(10'h000, 32'h8000_0002, 4'd1);
        offer_tick(10'h000, 32'h1234_5678, 4'd3);
        offer_tick(10'h3FF, 32'h1234_5679, 4'd12);
        offer_tick(10'h3FF, 32'h1234_567A, 4'd14);
        offer_tick(10'h000, 32'h1234_567B, 4'd8);
        offer_tick(10'h3FF, 32'h1234_567B, 4'd13);
        offer_tick(10'h000, 32'h1234_567C, 4'd11);

        // Widest window, starting just below the top of time so that release
        // stamps plus the window overflow 32 bits.
        set_window(16'hFFFF);
        tick_now   = 32'hFFFF_F000;
        key_levels = '0;
        run_keys(600, 1'b1);

        set_window(16'h0000);
        run_keys(150, 1'b0);

        set_window(16'h0001);
        run_keys(150, 1'b0);

        set_window(window_t'($urandom));
        tick_now = stamp_t'($urandom);
        run_keys(150, 1'b0);

        set_window(window_t'($urandom_range(2, 300)));
        run_keys(200, 1'b0);

        wait_drained();
        if (fail_count == 0)
            $display("keypad_press_tracker_top verification clean");
        else
            $display("keypad_press_tracker_top verification failed");
        $finish;
    end

endmodule
